// ===== src/jfq_pkg.sv =====
// shared types, constants and codes for the job queue with keyed removal
// no dependencies
package jfq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TASK_W      = 32;
    localparam int PID_W       = 23;
    localparam int STATUS_W    = 2;
    localparam int FUNC_W      = 2;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } state_t;

    typedef struct packed {
        logic capture;
        logic active;
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic [TASK_W-1:0]       tid;
        logic signed [PID_W-1:0] pid;
        logic                    tid_on;
        logic                    pid_on;
    } search_key_t;

endpackage

// ===== src/jfq_cell.sv =====
// one queue slot: holds a task id and pid, compares them with the search key
// and takes the newer neighbor's entry when the gap closes; uses jfq_pkg
module jfq_cell
    import jfq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctl_t               ctl,
    input  search_key_t             key,
    input  logic [TASK_W-1:0]       push_tid,
    input  logic signed [PID_W-1:0] push_pid,
    input  logic [TASK_W-1:0]       nbr_tid,
    input  logic signed [PID_W-1:0] nbr_pid,
    output logic [TASK_W-1:0]       tid,
    output logic signed [PID_W-1:0] pid,
    output logic                    hit,
    output logic                    match
);

    logic [TASK_W-1:0]       tid_reg;
    logic signed [PID_W-1:0] pid_reg;
    logic                    match_reg;

    assign hit = ctl.active
        && ((key.pid_on && (pid_reg == key.pid)) || (key.tid_on && (tid_reg == key.tid)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            match_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            tid_reg <= push_tid;
            pid_reg <= push_pid;
        end
        else if (ctl.shift)
        begin
            tid_reg <= nbr_tid;
            pid_reg <= nbr_pid;
        end
    end

    assign tid   = tid_reg;
    assign pid   = pid_reg;
    assign match = match_reg;

endmodule

// ===== src/job_fifo_with_keyed_removal.sv =====
// job queue with push, pop-oldest and find-and-remove; top level
// accept and compare in all cells, then shift and count update in the apply state
// done is high for one cycle after the shift, busy is high only during the shift cycle
// no new request is taken during the shift cycle; requests are accepted only in idle
// reset clears the entry count and the sequencer; slot contents stay undefined until pushed
// results cannot be stalled; uses jfq_pkg and jfq_cell
module job_fifo_with_keyed_removal
    import jfq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [FUNC_W-1:0]       func,
    input  logic [TASK_W-1:0]       task_id,
    input  logic signed [PID_W-1:0] pid,
    output logic                    busy,
    output logic                    done,
    output logic [TASK_W-1:0]       removed_task_id,
    output logic [STATUS_W-1:0]     status,
    output logic [COUNT_W-1:0]      entry_count
);

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [FUNC_W-1:0]       func_reg;
    logic [TASK_W-1:0]       data_tid_reg;
    logic signed [PID_W-1:0] data_pid_reg;
    logic [NUM_GROUPS-1:0]   gany_reg;
    logic                    done_reg, done_next;
    logic [TASK_W-1:0]       removed_reg, removed_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    logic                    accept;
    logic                    apply;
    search_key_t             key;
    logic [TASK_W-1:0]       cell_tid [QUEUE_DEPTH];
    logic signed [PID_W-1:0] cell_pid [QUEUE_DEPTH];
    logic [PAD_DEPTH-1:0]    hit_pad;
    logic [PAD_DEPTH-1:0]    match_pad;
    logic [PAD_DEPTH-1:0]    above;
    logic [PAD_DEPTH-1:0]    sel;
    logic [NUM_GROUPS-1:0]   gany_now;
    logic [NUM_GROUPS-1:0]   grp_above;
    logic [TASK_W-1:0]       sel_tid [PAD_DEPTH];
    logic [TASK_W-1:0]       find_tid;
    logic                    any_match;
    logic                    do_push, do_pop, do_find;

    assign accept = start && (state_reg == ST_IDLE);
    assign apply  = (state_reg == ST_APPLY);
    assign busy   = apply;

    assign key.tid    = task_id;
    assign key.pid    = pid;
    assign key.tid_on = (task_id != '0);
    assign key.pid_on = (pid != '1) && (func == FUNC_FIND);

    assign any_match = |gany_reg;
    assign do_push   = apply && (func_reg == FUNC_PUSH)
                       && (count_reg < COUNT_W'(QUEUE_DEPTH));
    assign do_pop    = apply && (func_reg == FUNC_POP) && (count_reg != '0);
    assign do_find   = apply && (func_reg == FUNC_FIND) && any_match;

    genvar i, g;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            cell_ctl_t               ctl;
            search_key_t             ckey;
            logic [TASK_W-1:0]       nb_tid;
            logic signed [PID_W-1:0] nb_pid;

            assign ctl.capture = accept;
            assign ctl.active  = (COUNT_W'(i) < count_reg);
            assign ctl.load    = do_push && (count_reg == COUNT_W'(i));
            assign ctl.shift   = do_pop || (do_find && !above[i]);

            assign ckey.tid    = key.tid;
            assign ckey.pid    = key.pid;
            assign ckey.pid_on = key.pid_on;
            assign ckey.tid_on = key.tid_on && (func == FUNC_FIND);

            if (i == QUEUE_DEPTH - 1)
            begin : g_top
                assign nb_tid = cell_tid[i];
                assign nb_pid = cell_pid[i];
            end
            else
            begin : g_mid
                assign nb_tid = cell_tid[i+1];
                assign nb_pid = cell_pid[i+1];
            end

            jfq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .key      (ckey),
                .push_tid (data_tid_reg),
                .push_pid (data_pid_reg),
                .nbr_tid  (nb_tid),
                .nbr_pid  (nb_pid),
                .tid      (cell_tid[i]),
                .pid      (cell_pid[i]),
                .hit      (hit_pad[i]),
                .match    (match_pad[i])
            );
        end

        for (i = QUEUE_DEPTH; i < PAD_DEPTH; i++)
        begin : g_pad
            assign hit_pad[i]   = 1'b0;
            assign match_pad[i] = 1'b0;
        end

        // newest match wins: a cell is selected when nothing newer matched
        for (i = 0; i < PAD_DEPTH; i++)
        begin : g_above
            if ((i % GROUP_SIZE) == GROUP_SIZE - 1)
            begin : g_edge
                assign above[i] = grp_above[i / GROUP_SIZE];
            end
            else
            begin : g_inner
                assign above[i] = above[i+1] | match_pad[i+1];
            end
            assign sel[i] = match_pad[i] && !above[i];
            if (i < QUEUE_DEPTH)
            begin : g_real
                assign sel_tid[i] = sel[i] ? cell_tid[i] : '0;
            end
            else
            begin : g_fill
                assign sel_tid[i] = '0;
            end
        end

        for (g = 0; g < NUM_GROUPS; g++)
        begin : g_group
            assign gany_now[g] = |hit_pad[g*GROUP_SIZE +: GROUP_SIZE];
            if (g == NUM_GROUPS - 1)
            begin : g_last
                assign grp_above[g] = 1'b0;
            end
            else
            begin : g_rest
                assign grp_above[g] = grp_above[g+1] | gany_reg[g+1];
            end
        end
    endgenerate

    always_comb
    begin
        find_tid = '0;
        for (int k = 0; k < PAD_DEPTH; k++)
        begin
            find_tid = find_tid | sel_tid[k];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        removed_next = removed_reg;
        status_next  = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next   = ST_IDLE;
                done_next    = 1'b1;
                removed_next = '0;
                status_next  = STATUS_NONE;
                case (func_reg)
                    FUNC_PUSH:
                    begin
                        if (do_push)
                        begin
                            count_next  = count_reg + COUNT_W'(1);
                            status_next = STATUS_DONE;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    FUNC_POP:
                    begin
                        if (do_pop)
                        begin
                            count_next   = count_reg - COUNT_W'(1);
                            removed_next = cell_tid[0];
                            status_next  = STATUS_DONE;
                        end
                    end
                    FUNC_FIND:
                    begin
                        if (do_find)
                        begin
                            count_next   = count_reg - COUNT_W'(1);
                            removed_next = find_tid;
                            status_next  = STATUS_DONE;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_NONE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            gany_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (accept)
            begin
                gany_reg <= gany_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            data_tid_reg <= task_id;
            data_pid_reg <= pid;
        end
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign done            = done_reg;
    assign removed_task_id = removed_reg;
    assign status          = status_reg;
    assign entry_count     = count_reg;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without entering the shift cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding shift cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> (entry_count == COUNT_W'(QUEUE_DEPTH)))
        else $error("push refused while queue not full");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for job_fifo_with_keyed_removal: a directed table, then random requests
// results checked against table values or a queue-based job list predictor; depends on jfq_pkg and the rtl
module tb_top
    import jfq_pkg::*;
();

    localparam logic [PID_W-1:0] PID_ANY   = '1;
    localparam int               NUM_RAND  = 1800;
    localparam int               MAX_CYCLE = 400000;

    typedef struct {
        logic [TASK_W-1:0]   rm;
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  cnt;
    } job_result_t;

    typedef struct {
        logic [FUNC_W-1:0]   op;
        logic [TASK_W-1:0]   tid;
        logic [PID_W-1:0]    pid;
        bit                  typed;
        job_result_t         res;
    } job_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic [FUNC_W-1:0]       func;
    logic [TASK_W-1:0]       task_id;
    logic signed [PID_W-1:0] pid;
    logic                    busy;
    logic                    done;
    logic [TASK_W-1:0]       removed_task_id;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      entry_count;

    logic [TASK_W-1:0] job_tids[$];
    logic [PID_W-1:0]  job_pids[$];
    job_result_t       pending_results[$];

    int errors;
    int cycles;
    int n_full;
    int n_empty_pop;
    int n_find_hit;
    int n_find_miss;
    int peak_count;
    int n_checked;

    // newest entries at the back of the job list
    job_row_t dir_rows [16] = '{
        '{FUNC_POP,  32'd0,          23'd0,        1'b1, '{32'd0,          STATUS_NONE, 7'd0}},
        '{FUNC_FIND, 32'd0,          PID_ANY,      1'b1, '{32'd0,          STATUS_NONE, 7'd0}},
        '{FUNC_PUSH, 32'hFFFF_FFFF,  23'h3F_FFFF,  1'b1, '{32'd0,          STATUS_DONE, 7'd1}},
        '{FUNC_PUSH, 32'd0,          PID_ANY,      1'b1, '{32'd0,          STATUS_DONE, 7'd2}},
        '{FUNC_PUSH, 32'd1,          23'd0,        1'b1, '{32'd0,          STATUS_DONE, 7'd3}},
        '{FUNC_PUSH, 32'h8000_0000,  23'h40_0000,  1'b1, '{32'd0,          STATUS_DONE, 7'd4}},
        '{FUNC_PUSH, 32'd5,          23'd5,        1'b1, '{32'd0,          STATUS_DONE, 7'd5}},
        '{FUNC_FIND, 32'd0,          PID_ANY,      1'b1, '{32'd0,          STATUS_NONE, 7'd5}},
        '{FUNC_FIND, 32'h0001_2345,  23'd7,        1'b1, '{32'd0,          STATUS_NONE, 7'd5}},
        '{FUNC_FIND, 32'd0,          23'd0,        1'b0, '{32'd0,          STATUS_DONE, 7'd0}},
        '{FUNC_FIND, 32'hFFFF_FFFF,  PID_ANY,      1'b1, '{32'hFFFF_FFFF,  STATUS_DONE, 7'd3}},
        '{FUNC_POP,  32'd0,          23'd0,        1'b1, '{32'd0,          STATUS_DONE, 7'd2}},
        '{FUNC_PUSH, 32'd9,          23'd5,        1'b0, '{32'd0,          STATUS_DONE, 7'd0}},
        '{FUNC_FIND, 32'd0,          23'd5,        1'b0, '{32'd0,          STATUS_DONE, 7'd0}},
        '{FUNC_FIND, 32'h8000_0000,  23'd5,        1'b0, '{32'd0,          STATUS_DONE, 7'd0}},
        '{FUNC_POP,  32'd0,          23'd0,        1'b1, '{32'h8000_0000,  STATUS_DONE, 7'd0}}
    };

    job_fifo_with_keyed_removal dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .func            (func),
        .task_id         (task_id),
        .pid             (pid),
        .busy            (busy),
        .done            (done),
        .removed_task_id (removed_task_id),
        .status          (status),
        .entry_count     (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic job_result_t apply_job_op(logic [FUNC_W-1:0] op,
                                                 logic [TASK_W-1:0] key_tid,
                                                 logic [PID_W-1:0] key_pid);
        job_result_t r;
        bit          pid_on;
        bit          tid_on;
        r.rm   = '0;
        r.st   = STATUS_NONE;
        pid_on = (key_pid != PID_ANY);
        tid_on = (key_tid != '0);
        case (op)
            FUNC_PUSH:
            begin
                if (job_tids.size() >= QUEUE_DEPTH)
                begin
                    r.st = STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    job_tids.push_back(key_tid);
                    job_pids.push_back(key_pid);
                    r.st = STATUS_DONE;
                end
            end
            FUNC_POP:
            begin
                if (job_tids.size() > 0)
                begin
                    r.rm = job_tids.pop_front();
                    void'(job_pids.pop_front());
                    r.st = STATUS_DONE;
                end
                else
                    n_empty_pop++;
            end
            FUNC_FIND:
            begin
                if (pid_on || tid_on)
                begin
                    for (int k = job_tids.size() - 1; k >= 0; k--)
                    begin
                        if ((pid_on && job_pids[k] == key_pid) ||
                            (tid_on && job_tids[k] == key_tid))
                        begin
                            r.rm = job_tids[k];
                            r.st = STATUS_DONE;
                            job_tids.delete(k);
                            job_pids.delete(k);
                            break;
                        end
                    end
                end
                if (r.st == STATUS_DONE)
                    n_find_hit++;
                else
                    n_find_miss++;
            end
            default: ;
        endcase
        r.cnt = COUNT_W'(job_tids.size());
        if (job_tids.size() > peak_count)
            peak_count = job_tids.size();
        return r;
    endfunction

    // request stays up until accepted; start is never dropped here
    task automatic issue_job(input logic [FUNC_W-1:0] op, input logic [TASK_W-1:0] key_tid,
                             input logic [PID_W-1:0] key_pid, input bit typed,
                             input job_result_t typed_res);
        job_result_t pred;
        start   <= 1'b1;
        func    <= op;
        task_id <= key_tid;
        pid     <= key_pid;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pred = apply_job_op(op, key_tid, key_pid);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int draw_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [TASK_W-1:0] draw_tid();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 22)
            return $urandom_range(1, 16);
        if (r < 26)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [PID_W-1:0] draw_pid();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return PID_ANY;
        if (r < 25)
            return PID_W'($urandom_range(0, 16));
        if (r < 28)
            return 23'h40_0000;
        if (r < 31)
            return 23'h3F_FFFF;
        return PID_W'($urandom);
    endfunction

    task automatic random_job(input int push_pct);
        logic [FUNC_W-1:0] op;
        logic [TASK_W-1:0] key_tid;
        logic [PID_W-1:0]  key_pid;
        job_result_t       none;
        int                r;
        int                idx;
        none    = '{'0, STATUS_NONE, '0};
        r       = $urandom_range(0, 99);
        key_tid = draw_tid();
        key_pid = draw_pid();
        if (r < push_pct)
        begin
            op = FUNC_PUSH;
            if (job_pids.size() > 0 && $urandom_range(0, 99) < 30)
                key_pid = job_pids[$urandom_range(0, job_pids.size() - 1)];
        end
        else if ($urandom_range(0, 99) < 40)
            op = FUNC_POP;
        else
        begin
            op = FUNC_FIND;
            if (job_tids.size() > 0 && $urandom_range(0, 99) < 75)
            begin
                idx = $urandom_range(0, job_tids.size() - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        key_tid = '0;
                        key_pid = job_pids[idx];
                    end
                    1:
                    begin
                        key_tid = job_tids[idx];
                        key_pid = PID_ANY;
                    end
                    default:
                    begin
                        key_tid = job_tids[idx];
                        key_pid = job_pids[$urandom_range(0, job_pids.size() - 1)];
                    end
                endcase
            end
        end
        issue_job(op, key_tid, key_pid, 1'b0, none);
    endtask

    always @(posedge clk)
    begin
        job_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: removed_task_id %0h status %0d",
                       removed_task_id, status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (removed_task_id !== want.rm)
                begin
                    $error("removed_task_id: expected %0h actual %0h", want.rm, removed_task_id);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d actual %0d", want.st, status);
                    errors++;
                end
                if (entry_count !== want.cnt)
                begin
                    $error("entry_count: expected %0d actual %0d", want.cnt, entry_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("job_fifo_with_keyed_removal regression: fail");
            $finish;
        end
    end

    initial
    begin
        int push_pct;
        bit quiet;
        errors      = 0;
        cycles      = 0;
        n_full      = 0;
        n_empty_pop = 0;
        n_find_hit  = 0;
        n_find_miss = 0;
        peak_count  = 0;
        n_checked   = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        func    <= FUNC_PUSH;
        task_id <= '0;
        pid     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            issue_job(dir_rows[i].op, dir_rows[i].tid, dir_rows[i].pid,
                      dir_rows[i].typed, dir_rows[i].res);
            idle_gap(draw_gap(i < 6));
        end

        for (int blk = 0; blk < NUM_RAND / 100; blk++)
        begin
            case (blk % 4)
                1:       push_pct = 92;
                3:       push_pct = 8;
                default: push_pct = $urandom_range(25, 65);
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++)
            begin
                random_job(push_pct);
                idle_gap(draw_gap(quiet));
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("checked %0d results; queue peak %0d entries, %0d refused pushes, %0d empty pops",
                 n_checked, peak_count, n_full, n_empty_pop);
        $display("find-remove: %0d hits, %0d misses or wildcard searches",
                 n_find_hit, n_find_miss);
        if (errors == 0)
            $display("job_fifo_with_keyed_removal regression: pass");
        else
            $display("job_fifo_with_keyed_removal regression: fail");
        $finish;
    end

endmodule
